@@ hw/rtl/varint_prefixed_field_deframer_macros.svh @@
// ---------------------------------------------------------------------------
// Varint deframer assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef VARINT_PREFIXED_FIELD_DEFRAMER_MACROS_SVH
`define VARINT_PREFIXED_FIELD_DEFRAMER_MACROS_SVH

// same-cycle implication
`define VPFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/vpfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Varint deframer package
// Widths, phase/kind/error codes and beat types shared by the deframer.
// ---------------------------------------------------------------------------
package vpfd_pkg;

  localparam int unsigned LenW = 62;

  localparam logic [LenW-1:0] MaxLengthRst = LenW'(65535);
  localparam logic [LenW-1:0] NonMin1      = LenW'(64'h40);
  localparam logic [LenW-1:0] NonMin2      = LenW'(64'h4000);
  localparam logic [LenW-1:0] NonMin3      = LenW'(64'h4000_0000);

  localparam logic [1:0] PhStart   = 2'd0;
  localparam logic [1:0] PhPrefix  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhDrop    = 2'd3;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindEmpty   = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrNonMin    = 2'd1;
  localparam logic [1:0] ErrExceeds   = 2'd2;
  localparam logic [1:0] ErrTruncated = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      payload_byte;
    logic            field_last;
    logic [LenW-1:0] field_length;
    logic [1:0]      error_code;
  } res_beat_t;

endpackage

@@ hw/rtl/vpfd_in_reg.sv @@
// ---------------------------------------------------------------------------
// Varint deframer input register
// Holds one input beat; refills in the cycle the held beat is consumed.
// ---------------------------------------------------------------------------
module vpfd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vpfd_pkg::in_beat_t in_beat_i,
  output logic              beat_valid_o,
  input  logic              beat_take_i,
  output vpfd_pkg::in_beat_t beat_o
);

  logic               valid_q;
  vpfd_pkg::in_beat_t beat_q;

  assign in_ready_o   = !valid_q || beat_take_i;
  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= in_beat_i;
    end
  end

endmodule

@@ hw/rtl/vpfd_core.sv @@
// ---------------------------------------------------------------------------
// Varint deframer core
// Prefix decode, length checks, payload count and drop phase, one beat per
// cycle in which fire_i is high.
// ---------------------------------------------------------------------------
`include "varint_prefixed_field_deframer_macros.svh"

module vpfd_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  vpfd_pkg::in_beat_t            beat_i,
  input  logic [vpfd_pkg::LenW-1:0]     max_length_i,
  output logic                          res_valid_o,
  output vpfd_pkg::res_beat_t           res_o
);

  localparam int unsigned LenW = vpfd_pkg::LenW;

  logic [1:0]      phase_q, phase_d;
  logic [2:0]      left_q, left_d;
  logic [1:0]      size_q, size_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [LenW-1:0] pay_q, pay_d;

  logic [7:0] b;
  logic       fin;
  logic       nonmin, over, do_check, do_fail;
  logic [1:0] fail_code;

  assign b   = beat_i.in_byte;
  assign fin = beat_i.buffer_end;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    size_d    = size_q;
    acc_d     = acc_q;
    pay_d     = pay_q;
    do_check  = 1'b0;
    do_fail   = 1'b0;
    fail_code = vpfd_pkg::ErrNone;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      vpfd_pkg::PhStart: begin
        size_d = b[7:6];
        acc_d  = LenW'(b[5:0]);
        case (b[7:6])
          2'd0:    left_d = 3'd0;
          2'd1:    left_d = 3'd1;
          2'd2:    left_d = 3'd3;
          default: left_d = 3'd7;
        endcase
        if (left_d == 3'd0) begin
          do_check = 1'b1;
        end else if (fin) begin
          do_fail   = 1'b1;
          fail_code = vpfd_pkg::ErrTruncated;
        end else begin
          phase_d = vpfd_pkg::PhPrefix;
        end
      end
      vpfd_pkg::PhPrefix: begin
        acc_d  = {acc_q[LenW-9:0], b};
        left_d = left_q - 3'd1;
        if (left_d == 3'd0) begin
          do_check = 1'b1;
        end else if (fin) begin
          do_fail   = 1'b1;
          fail_code = vpfd_pkg::ErrTruncated;
        end
      end
      vpfd_pkg::PhPayload: begin
        pay_d = pay_q - LenW'(1);
        if (pay_d == '0) begin
          phase_d            = vpfd_pkg::PhStart;
          res_valid_o        = 1'b1;
          res_o.kind         = vpfd_pkg::KindPayload;
          res_o.payload_byte = b;
          res_o.field_last   = 1'b1;
          res_o.field_length = acc_q;
        end else if (fin) begin
          do_fail   = 1'b1;
          fail_code = vpfd_pkg::ErrTruncated;
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = vpfd_pkg::KindPayload;
          res_o.payload_byte = b;
          res_o.field_length = acc_q;
        end
      end
      default: begin
        if (fin) begin
          phase_d = vpfd_pkg::PhStart;
        end
      end
    endcase

    nonmin = (size_d == 2'd1 && acc_d < vpfd_pkg::NonMin1) ||
             (size_d == 2'd2 && acc_d < vpfd_pkg::NonMin2) ||
             (size_d == 2'd3 && acc_d < vpfd_pkg::NonMin3);
    over   = acc_d > max_length_i;

    if (do_check) begin
      if (nonmin) begin
        do_fail   = 1'b1;
        fail_code = vpfd_pkg::ErrNonMin;
      end else if (over) begin
        do_fail   = 1'b1;
        fail_code = vpfd_pkg::ErrExceeds;
      end else if (acc_d == '0) begin
        phase_d     = vpfd_pkg::PhStart;
        res_valid_o = 1'b1;
        res_o.kind  = vpfd_pkg::KindEmpty;
      end else if (fin) begin
        do_fail   = 1'b1;
        fail_code = vpfd_pkg::ErrTruncated;
      end else begin
        pay_d   = acc_d;
        phase_d = vpfd_pkg::PhPayload;
      end
    end

    if (do_fail) begin
      phase_d          = fin ? vpfd_pkg::PhStart : vpfd_pkg::PhDrop;
      left_d           = 3'd0;
      pay_d            = '0;
      res_valid_o      = 1'b1;
      res_o            = '0;
      res_o.kind       = vpfd_pkg::KindError;
      res_o.error_code = fail_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= vpfd_pkg::PhStart;
      left_q  <= 3'd0;
      size_q  <= 2'd0;
      acc_q   <= '0;
      pay_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      size_q  <= size_d;
      acc_q   <= acc_d;
      pay_q   <= pay_d;
    end
  end

  `VPFD_ASSERT_IMP(a_pay_nonzero, phase_q == vpfd_pkg::PhPayload, pay_q != '0, "payload count zero in payload phase")
  `VPFD_ASSERT_IMP(a_prefix_left, phase_q == vpfd_pkg::PhPrefix, left_q != 3'd0, "no prefix bytes left in prefix phase")
  `VPFD_ASSERT_IMP(a_err_code, res_valid_o && res_o.kind == vpfd_pkg::KindError, res_o.error_code != vpfd_pkg::ErrNone, "error beat without code")
  `VPFD_ASSERT_NXT(a_last_start, fire_i && res_valid_o && res_o.field_last, phase_q == vpfd_pkg::PhStart, "last payload beat not followed by prefix start")

endmodule

@@ hw/rtl/vpfd_out_reg.sv @@
// ---------------------------------------------------------------------------
// Varint deframer result register
// Holds one result beat for the downstream side; reloads as it drains.
// ---------------------------------------------------------------------------
module vpfd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  output logic                room_o,
  input  logic                load_i,
  input  vpfd_pkg::res_beat_t res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vpfd_pkg::res_beat_t res_o
);

  logic                valid_q;
  vpfd_pkg::res_beat_t res_q;

  assign room_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (room_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && room_o) begin
      res_q <= res_i;
    end
  end

endmodule

@@ hw/rtl/varint_prefixed_field_deframer.sv @@
// A beat is held in the input register and decoded combinationally by the
// core; its result is registered in the result register that drives the output.
// Throughput: one input beat per cycle, bounded only by output backpressure
// on the single result register.
// Reset: asynchronous, active low; clears phase and counters, empties both
// registers and sets max_length to 65535.
// ---------------------------------------------------------------------------
// Varint length-prefixed field deframer
// Splits a byte stream into varint-length-prefixed fields, checks lengths.
// ---------------------------------------------------------------------------
module varint_prefixed_field_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                in_byte_i,
  input  logic                      buffer_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                payload_byte_o,
  output logic                      field_last_o,
  output logic [vpfd_pkg::LenW-1:0] field_length_o,
  output logic [1:0]                error_code_o,
  input  logic                      cfg_we_i,
  input  logic [vpfd_pkg::LenW-1:0] cfg_wdata_i
);

  logic [vpfd_pkg::LenW-1:0] max_length_q;

  vpfd_pkg::in_beat_t  in_beat, core_beat;
  vpfd_pkg::res_beat_t core_res, out_res;
  logic beat_valid, room, fire, res_valid;

  assign in_beat.in_byte    = in_byte_i;
  assign in_beat.buffer_end = buffer_end_i;
  assign fire = beat_valid && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= vpfd_pkg::MaxLengthRst;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  vpfd_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat),
    .beat_valid_o (beat_valid),
    .beat_take_i  (fire),
    .beat_o       (core_beat)
  );

  vpfd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .beat_i       (core_beat),
    .max_length_i (max_length_q),
    .res_valid_o  (res_valid),
    .res_o        (core_res)
  );

  vpfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .room_o      (room),
    .load_i      (fire && res_valid),
    .res_i       (core_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign field_last_o   = out_res.field_last;
  assign field_length_o = out_res.field_length;
  assign error_code_o   = out_res.error_code;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Varint deframer testbench
// Feeds length-prefixed byte buffers through the deframer under several
// max_length settings and flow-control patterns, and checks every output beat
// against an in-bench decoder of the same framing rules.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned LenW = vpfd_pkg::LenW;
  localparam logic [1:0] Pfx1 = 2'd0;
  localparam logic [1:0] Pfx2 = 2'd1;
  localparam logic [1:0] Pfx4 = 2'd2;
  localparam logic [1:0] Pfx8 = 2'd3;
  localparam logic [LenW-1:0] LenAll = '1;
  localparam int unsigned TimeoutCycles = 200_000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic [7:0]      in_byte_i;
  logic            buffer_end_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [1:0]      kind_o;
  logic [7:0]      payload_byte_o;
  logic            field_last_o;
  logic [LenW-1:0] field_length_o;
  logic [1:0]      error_code_o;
  logic            cfg_we_i;
  logic [LenW-1:0] cfg_wdata_i;

  varint_prefixed_field_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .buffer_end_i   (buffer_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .field_last_o   (field_last_o),
    .field_length_o (field_length_o),
    .error_code_o   (error_code_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // decoder state
  logic [1:0]      cur_phase;
  logic [2:0]      pfx_left;
  logic [1:0]      size_code;
  logic [LenW-1:0] len_acc;
  logic [LenW-1:0] pay_left;
  logic [LenW-1:0] max_len;

  vpfd_pkg::in_beat_t  byte_stream[$];
  vpfd_pkg::res_beat_t pending_results[$];
  vpfd_pkg::in_beat_t  next_beat;
  vpfd_pkg::res_beat_t seen;
  vpfd_pkg::res_beat_t want;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatches;
  int unsigned beats_in;
  int unsigned n_payload;
  int unsigned n_empty;
  int unsigned n_error;
  int unsigned n_settings;

  function automatic void post_result(logic [1:0] k, logic [7:0] b, logic l,
                                      logic [LenW-1:0] n, logic [1:0] e);
    vpfd_pkg::res_beat_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.field_last   = l;
    r.field_length = n;
    r.error_code   = e;
    pending_results.push_back(r);
  endfunction

  function automatic void reject(logic [1:0] code, logic at_end);
    cur_phase = at_end ? vpfd_pkg::PhStart : vpfd_pkg::PhDrop;
    pfx_left  = '0;
    pay_left  = '0;
    post_result(vpfd_pkg::KindError, 8'h00, 1'b0, '0, code);
  endfunction

  function automatic void close_length(logic at_end);
    logic nonmin;
    nonmin = (size_code == Pfx2 && len_acc < vpfd_pkg::NonMin1) ||
             (size_code == Pfx4 && len_acc < vpfd_pkg::NonMin2) ||
             (size_code == Pfx8 && len_acc < vpfd_pkg::NonMin3);
    if (nonmin) begin
      reject(vpfd_pkg::ErrNonMin, at_end);
    end else if (len_acc > max_len) begin
      reject(vpfd_pkg::ErrExceeds, at_end);
    end else if (len_acc == '0) begin
      cur_phase = vpfd_pkg::PhStart;
      post_result(vpfd_pkg::KindEmpty, 8'h00, 1'b0, '0, vpfd_pkg::ErrNone);
    end else if (at_end) begin
      reject(vpfd_pkg::ErrTruncated, 1'b1);
    end else begin
      pay_left  = len_acc;
      cur_phase = vpfd_pkg::PhPayload;
    end
  endfunction

  function automatic void deframe_beat(logic [7:0] b, logic at_end);
    case (cur_phase)
      vpfd_pkg::PhStart: begin
        size_code = b[7:6];
        len_acc   = LenW'(b[5:0]);
        pfx_left  = 3'((4'd1 << size_code) - 4'd1);
        if (pfx_left == 3'd0) close_length(at_end);
        else if (at_end) reject(vpfd_pkg::ErrTruncated, 1'b1);
        else cur_phase = vpfd_pkg::PhPrefix;
      end
      vpfd_pkg::PhPrefix: begin
        len_acc  = {len_acc[LenW-9:0], b};
        pfx_left = pfx_left - 3'd1;
        if (pfx_left == 3'd0) close_length(at_end);
        else if (at_end) reject(vpfd_pkg::ErrTruncated, 1'b1);
      end
      vpfd_pkg::PhPayload: begin
        pay_left = pay_left - 1'b1;
        if (pay_left == '0) begin
          cur_phase = vpfd_pkg::PhStart;
          post_result(vpfd_pkg::KindPayload, b, 1'b1, len_acc, vpfd_pkg::ErrNone);
        end else if (at_end) begin
          reject(vpfd_pkg::ErrTruncated, 1'b1);
        end else begin
          post_result(vpfd_pkg::KindPayload, b, 1'b0, len_acc, vpfd_pkg::ErrNone);
        end
      end
      default: begin
        if (at_end) cur_phase = vpfd_pkg::PhStart;
      end
    endcase
  endfunction

  // stimulus helpers
  function automatic void put(logic [7:0] b, logic e);
    vpfd_pkg::in_beat_t t;
    t.in_byte    = b;
    t.buffer_end = e;
    byte_stream.push_back(t);
  endfunction

  function automatic void end_buffer();
    vpfd_pkg::in_beat_t t;
    t = byte_stream.pop_back();
    t.buffer_end = 1'b1;
    byte_stream.push_back(t);
  endfunction

  function automatic logic [1:0] min_code(logic [LenW-1:0] v);
    if (v < vpfd_pkg::NonMin1) return Pfx1;
    if (v < vpfd_pkg::NonMin2) return Pfx2;
    if (v < vpfd_pkg::NonMin3) return Pfx4;
    return Pfx8;
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[LenW-1:0] >> $urandom_range(0, LenW - 1);
  endfunction

  function automatic void put_prefix(logic [LenW-1:0] v, logic [1:0] sc, int cut);
    logic [63:0] w;
    logic [7:0]  b;
    int          nb;
    w  = {2'b00, v};
    nb = 1 << sc;
    for (int k = 0; k < nb && k < cut; k++) begin
      b = w[8*(nb-1-k) +: 8];
      if (k == 0) b[7:6] = sc;
      put(b, 1'b0);
    end
  endfunction

  function automatic void put_payload(int unsigned n);
    for (int unsigned i = 0; i < n; i++) put(8'($urandom_range(255)), 1'b0);
  endfunction

  // one buffer: mostly well-formed fields, some broken ones and noise
  function automatic void gen_buffer();
    int unsigned     nf;
    int unsigned     r;
    logic [LenW-1:0] v;
    logic [1:0]      sc;
    nf = $urandom_range(1, 4);
    for (int unsigned f = 0; f < nf; f++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        v  = '0;
        sc = (r < 3) ? 2'($urandom_range(1, 3)) : Pfx1;
      end else if (r < 60) begin
        v  = LenW'($urandom_range(1, 12));
        sc = min_code(v);
      end else if (r < 66) begin
        v  = LenW'($urandom_range(13, 300));
        sc = min_code(v);
      end else if (r < 73) begin
        v  = (max_len == LenAll || r < 69) ? max_len : max_len + 1'b1;
        sc = min_code(v);
      end else if (r < 80) begin
        v  = rand_len() >> 32;
        sc = 2'($urandom_range(int'(min_code(v)) + 1, 3));
      end else if (r < 88) begin
        v  = rand_len();
        sc = min_code(v);
      end else if (r < 95) begin
        sc = 2'($urandom_range(0, 3));
        put_prefix(rand_len(), sc, $urandom_range(1, 1 << sc));
        end_buffer();
        return;
      end else begin
        put_payload($urandom_range(1, 6));
        end_buffer();
        return;
      end
      put_prefix(v, sc, 8);
      if (v > max_len || sc != min_code(v)) begin
        put_payload($urandom_range(0, 2));
        end_buffer();
        return;
      end
      if (v > 300) begin
        put_payload($urandom_range(0, 3));
        end_buffer();
        return;
      end
      if (v > 1 && $urandom_range(9) == 0) begin
        put_payload($urandom_range(0, int'(v) - 1));
        end_buffer();
        return;
      end
      put_payload(int'(v));
    end
    end_buffer();
  endfunction

  task automatic write_limit(logic [LenW-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len      = v;
    n_settings++;
  endtask

  task automatic drain();
    while (byte_stream.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("timeout: %0d results still expected", pending_results.size());
    $display("[varint_prefixed_field_deframer] ERROR");
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        deframe_beat(in_byte_i, buffer_end_i);
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_beat     = byte_stream.pop_front();
          in_valid_i   <= 1'b1;
          in_byte_i    <= next_beat.in_byte;
          buffer_end_i <= next_beat.buffer_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.kind         = kind_o;
        seen.payload_byte = payload_byte_o;
        seen.field_last   = field_last_o;
        seen.field_length = field_length_o;
        seen.error_code   = error_code_o;
        if (seen.kind == vpfd_pkg::KindPayload) n_payload++;
        else if (seen.kind == vpfd_pkg::KindEmpty) n_empty++;
        else n_error++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: kind %0d byte %02h last %0b len %0d err %0d",
                     seen.kind, seen.payload_byte, seen.field_last,
                     seen.field_length, seen.error_code);
        end else begin
          want = pending_results.pop_front();
          if (seen.kind !== want.kind || seen.payload_byte !== want.payload_byte ||
              seen.field_last !== want.field_last ||
              seen.field_length !== want.field_length ||
              seen.error_code !== want.error_code) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp kind %0d byte %02h last %0b len %0d err %0d",
                       want.kind, want.payload_byte, want.field_last,
                       want.field_length, want.error_code);
              $display("          got kind %0d byte %02h last %0b len %0d err %0d",
                       seen.kind, seen.payload_byte, seen.field_last,
                       seen.field_length, seen.error_code);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    logic [LenW-1:0] limits[8];
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    buffer_end_i   = 1'b0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    cur_phase      = vpfd_pkg::PhStart;
    pfx_left       = '0;
    size_code      = '0;
    len_acc        = '0;
    pay_left       = '0;
    max_len        = vpfd_pkg::MaxLengthRst;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatches     = 0;
    beats_in       = 0;
    n_payload      = 0;
    n_empty        = 0;
    n_error        = 0;
    n_settings     = 1;
    limits = '{'0, LenW'(255), vpfd_pkg::MaxLengthRst, LenAll, rand_len(),
               LenW'(255), LenAll, rand_len()};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset limit of 65535
    @(negedge clk_i);
    put(8'h00, 1'b1);
    put(8'h03, 1'b0); put(8'hff, 1'b0); put(8'h00, 1'b0); put(8'ha5, 1'b1);
    put(8'h40, 1'b0); put(8'h05, 1'b0); put(8'h77, 1'b1);
    put(8'h80, 1'b0); put(8'h01, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b1);
    put(8'hc0, 1'b1);
    put(8'h05, 1'b1);
    put(8'h04, 1'b0); put(8'h11, 1'b0); put(8'h22, 1'b1);
    put(8'h7f, 1'b0); put(8'hff, 1'b1);
    drain();

    // directed, zero limit: non-minimal wins over exceeding the limit
    write_limit('0);
    @(negedge clk_i);
    put(8'h00, 1'b1);
    put(8'h01, 1'b1);
    put(8'h40, 1'b0); put(8'h01, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      src_idle_pct   = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 6 : 0;
      sink_stall_pct = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 6 : 0;
      @(negedge clk_i);
      while (byte_stream.size() < 150) gen_buffer();
      drain();
    end

    $display("%0d bytes in over %0d max_length settings and four flow patterns",
             beats_in, n_settings);
    $display("checked %0d payload, %0d empty-field and %0d error beats",
             n_payload, n_empty, n_error);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[varint_prefixed_field_deframer] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[varint_prefixed_field_deframer] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/vpfd_pkg.sv
hw/rtl/vpfd_in_reg.sv
hw/rtl/vpfd_core.sv
hw/rtl/vpfd_out_reg.sv
hw/rtl/varint_prefixed_field_deframer.sv
tb/testbench.sv
